// ===== src/rws_pkg.sv =====
// Shared types and constants for the roulette wheel selector.
// No dependencies; used by rws_div and roulette_wheel_selector.
package rws_pkg;

  localparam int SCORE_W = 24;
  localparam int RAND_W  = 31;
  localparam int OUT_W   = 7;
  localparam int CFG_W   = 8;
  localparam int PROD_W  = SCORE_W + RAND_W;
  // product >> 16, padded to an even width for the radix-4 divider
  localparam int QUO_W     = 40;
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [RAND_W-1:0] WHEEL_TOP = {RAND_W{1'b1}};
  localparam logic [CFG_W-1:0]  POP_SIZE_RESET = 8'd100;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_L_MUL  = 8'b0000_0010,
    S_L_DST  = 8'b0000_0100,
    S_L_DIV  = 8'b0000_1000,
    S_L_WR   = 8'b0001_0000,
    S_L_LAST = 8'b0010_0000,
    S_D_SCAN = 8'b0100_0000,
    S_D_OUT  = 8'b1000_0000
  } state_t;

endpackage

// ===== src/rws_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle.
// Depends on rws_pkg for the dividend width and step count.
module rws_div #(
  parameter int DW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rws_pkg::QUO_W-1:0] dividend,
  input  logic [DW-1:0]            divisor,
  output logic                     busy,
  output logic                     done,
  output logic [rws_pkg::QUO_W-1:0] quotient
);

  logic [rws_pkg::QUO_W-1:0]  dq;
  logic [DW-1:0]              rem;
  logic [DW-1:0]              dvs;
  logic [rws_pkg::STEP_W-1:0] cnt;
  logic [rws_pkg::QUO_W-1:0]  dq_next;
  logic [DW-1:0]              rem_next;

  always_comb begin
    logic [DW:0] t;
    dq_next  = dq;
    rem_next = rem;
    for (int k = 0; k < 2; k++) begin
      t       = {rem_next, dq_next[rws_pkg::QUO_W-1]};
      dq_next = {dq_next[rws_pkg::QUO_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t          = t - {1'b0, dvs};
        dq_next[0] = 1'b1;
      end
      rem_next = t[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == rws_pkg::STEP_W'(rws_pkg::DIV_STEPS - 1));
      if (start) begin
        dq   <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        dq  <= dq_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == rws_pkg::STEP_W'(rws_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = dq;

endmodule

// ===== src/roulette_wheel_selector.sv =====
// Roulette wheel selector: cumulative table in one synchronous RAM,
// loads scale and accumulate scores, draws scan for the first entry >= value (else the last entry).
// Depends on rws_pkg and rws_div.
//
//  channel  handshake                   payload
//  item     item_valid / item_ready     opcode, score, random_value
//  result   result_valid / result_ready selected_index
//  config   cfg_we                      cfg_wdata (pop_size)
//
// Load: each transaction multiplies, starts the radix-4 divide by size, waits for it and writes the table,
//   with an extra write of the last entry when it completes the table.
// Draw: the scan reads entries upward from index 0 to the hit, then the result is registered.
// One transaction is in work at a time; item_ready is high only when idle.
// The result register frees the core: a new item is taken while a result waits.
// Synchronous reset clears control state; the table RAM is not cleared.
module roulette_wheel_selector #(
  parameter int POP_MAX = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic                       opcode,
  input  logic [rws_pkg::SCORE_W-1:0] score,
  input  logic [rws_pkg::RAND_W-1:0]  random_value,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [rws_pkg::OUT_W-1:0]   selected_index,
  input  logic                       cfg_we,
  input  logic [rws_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int N_W   = $clog2(POP_MAX + 1);
  localparam int IDX_W = $clog2(POP_MAX);

  rws_pkg::state_t state;

  logic [rws_pkg::CFG_W-1:0]  pop_size;
  logic [N_W-1:0]             n;
  logic [rws_pkg::SCORE_W-1:0] score_q;
  logic [rws_pkg::RAND_W-1:0]  rv_q;
  logic [rws_pkg::PROD_W-1:0]  prod;
  logic [rws_pkg::RAND_W-1:0]  total;
  logic [IDX_W-1:0]           count;
  logic [N_W-1:0]             scan_addr;
  logic [IDX_W-1:0]           cmp_idx;
  logic                       rd_pend;
  logic [IDX_W-1:0]           result_idx;

  logic [rws_pkg::RAND_W-1:0] cum_mem [POP_MAX];
  logic [rws_pkg::RAND_W-1:0] mem_q;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [rws_pkg::RAND_W-1:0] mem_wdata;

  logic                       div_start;
  logic                       div_busy;
  logic                       div_done;
  logic [rws_pkg::QUO_W-1:0]  div_quo;
  logic [rws_pkg::QUO_W-1:0]  sum;
  logic [rws_pkg::RAND_W-1:0] total_next;
  logic                       out_free;

  always_comb begin
    if (pop_size < 8'd2) begin
      n = N_W'(2);
    end else if (int'(pop_size) > POP_MAX) begin
      n = N_W'(POP_MAX);
    end else begin
      n = N_W'(pop_size);
    end
  end

  assign item_ready = (state == rws_pkg::S_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign div_start  = (state == rws_pkg::S_L_DST);

  assign sum = rws_pkg::QUO_W'(total) + div_quo;
  assign total_next = (sum > rws_pkg::QUO_W'(rws_pkg::WHEEL_TOP)) ? rws_pkg::WHEEL_TOP
                                                                  : sum[rws_pkg::RAND_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count;
    mem_wdata = total_next;
    if (state == rws_pkg::S_L_WR) begin
      mem_we = 1'b1;
    end else if (state == rws_pkg::S_L_LAST) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(n - 1'b1);
      mem_wdata = rws_pkg::WHEEL_TOP;
    end
  end

  rws_div #(
    .DW (N_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rws_pkg::QUO_W'(prod[rws_pkg::PROD_W-1:16])),
    .divisor  (n),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cum_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rws_pkg::S_D_SCAN) begin
      mem_q <= cum_mem[scan_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rws_pkg::S_IDLE;
      pop_size     <= rws_pkg::POP_SIZE_RESET;
      total        <= '0;
      count        <= '0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pop_size <= cfg_wdata;
      end
      if (result_valid && result_ready && state != rws_pkg::S_D_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        rws_pkg::S_IDLE: begin
          if (item_valid) begin
            score_q   <= score;
            rv_q      <= random_value;
            scan_addr <= '0;
            rd_pend   <= 1'b0;
            state     <= (opcode == rws_pkg::OP_DRAW) ? rws_pkg::S_D_SCAN : rws_pkg::S_L_MUL;
          end
        end
        rws_pkg::S_L_MUL: begin
          prod <= rws_pkg::PROD_W'(score_q) * rws_pkg::PROD_W'(rws_pkg::WHEEL_TOP);
          // table complete (or size shrank): start a new one
          if (N_W'(count) >= n - 1'b1) begin
            total <= '0;
            count <= '0;
          end
          state <= rws_pkg::S_L_DST;
        end
        rws_pkg::S_L_DST: begin
          state <= rws_pkg::S_L_DIV;
        end
        rws_pkg::S_L_DIV: begin
          if (div_done) begin
            state <= rws_pkg::S_L_WR;
          end
        end
        rws_pkg::S_L_WR: begin
          total <= total_next;
          count <= count + 1'b1;
          state <= (N_W'(count) + 1'b1 == n - 1'b1) ? rws_pkg::S_L_LAST : rws_pkg::S_IDLE;
        end
        rws_pkg::S_L_LAST: begin
          state <= rws_pkg::S_IDLE;
        end
        rws_pkg::S_D_SCAN: begin
          cmp_idx   <= scan_addr[IDX_W-1:0];
          scan_addr <= scan_addr + 1'b1;
          if (rd_pend && (mem_q >= rv_q || N_W'(cmp_idx) == n - 1'b1)) begin
            result_idx <= cmp_idx;
            rd_pend    <= 1'b0;
            state      <= rws_pkg::S_D_OUT;
          end else begin
            rd_pend <= 1'b1;
          end
        end
        rws_pkg::S_D_OUT: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            selected_index <= rws_pkg::OUT_W'(result_idx);
            state          <= rws_pkg::S_IDLE;
          end
        end
        default: begin
          state <= rws_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !div_busy)
    else $error("divider busy while accepting a transaction");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == rws_pkg::S_L_WR) |-> (N_W'(count) < n - 1'b1))
    else $error("table write past the last running entry");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == rws_pkg::S_D_SCAN && rd_pend) |-> (N_W'(cmp_idx) < n))
    else $error("scan compared an entry beyond the table size");

  a_result_issued: assert property (@(posedge clk) disable iff (rst)
    (state == rws_pkg::S_D_OUT && out_free) |=> (result_valid && state == rws_pkg::S_IDLE))
    else $error("finished draw did not reach the result register");

endmodule

// ===== dv/tb_roulette_wheel_selector.sv =====
// Testbench for roulette_wheel_selector: queue-fed driver, result monitor and a
// transaction-level predictor of the cumulative wheel table and its lower-bound search.
// Depends on rws_pkg and the RTL under src/.
module tb_roulette_wheel_selector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WHEEL_MAX = 128;
  localparam int WIDX_W = $clog2(WHEEL_MAX);
  localparam int TAIL = 40;
  localparam int unsigned LIMIT = 1500000;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct {
    logic                        op;
    logic [rws_pkg::SCORE_W-1:0] sc;
    logic [rws_pkg::RAND_W-1:0]  rv;
    int                          aim;    // >= 0: rv set at issue to wheel[aim mod size] + nudge
    int                          nudge;
  } req_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_ready;
  logic                        opcode = rws_pkg::OP_LOAD;
  logic [rws_pkg::SCORE_W-1:0] score = '0;
  logic [rws_pkg::RAND_W-1:0]  random_value = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  logic [rws_pkg::OUT_W-1:0]   selected_index;
  logic                        cfg_we = 1'b0;
  logic [rws_pkg::CFG_W-1:0]   cfg_wdata = '0;

  req_t                      pending[$];
  logic [rws_pkg::OUT_W-1:0] expected_picks[$];
  req_t                      nxt_req;
  int                        send_gap = 0;
  int                        take_wait = 0;
  logic                      item_taken = 1'b0;
  logic                      res_taken = 1'b0;
  bit                        calm = 1'b0;
  int                        errors = 0;
  int unsigned               cycle_count = 0;

  // predictor state
  logic [rws_pkg::CFG_W-1:0]  wheel_size = rws_pkg::POP_SIZE_RESET;
  logic [rws_pkg::RAND_W-1:0] wheel [WHEEL_MAX] = '{default: '0};
  logic [rws_pkg::RAND_W-1:0] total = '0;
  int unsigned                filled = 0;

  roulette_wheel_selector #(.POP_MAX(WHEEL_MAX)) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .opcode(opcode),
    .score(score),
    .random_value(random_value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .selected_index(selected_index),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_size();
    int unsigned n;
    n = wheel_size;
    if (n < 2) n = 2;
    if (n > WHEEL_MAX) n = WHEEL_MAX;
    return n;
  endfunction

  function automatic int pace();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic apply_item(input logic op, input logic [rws_pkg::SCORE_W-1:0] sc,
                            input logic [rws_pkg::RAND_W-1:0] rv);
    int unsigned n;
    logic [63:0] step;
    logic [63:0] sum;
    int pick;
    bit hit;
    n = eff_size();
    if (op == rws_pkg::OP_LOAD) begin
      if (filled >= n - 1) begin
        total = '0;
        filled = 0;
      end
      step = (64'(sc) * 64'(rws_pkg::WHEEL_TOP)) / (64'd65536 * 64'(n));
      sum = 64'(total) + step;
      if (sum > 64'(rws_pkg::WHEEL_TOP)) sum = 64'(rws_pkg::WHEEL_TOP);
      total = sum[rws_pkg::RAND_W-1:0];
      wheel[WIDX_W'(filled)] = total;
      filled++;
      if (filled == n - 1) wheel[WIDX_W'(n - 1)] = rws_pkg::WHEEL_TOP;
    end else begin
      pick = n - 1;
      hit = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!hit && wheel[WIDX_W'(i)] >= rv) begin
          pick = i;
          hit = 1'b1;
        end
      end
      expected_picks.insert(expected_picks.size(), rws_pkg::OUT_W'(pick));
    end
  endtask

  task automatic queue_item(input logic op, input logic [rws_pkg::SCORE_W-1:0] sc,
                            input logic [rws_pkg::RAND_W-1:0] rv, input int aim,
                            input int nudge);
    req_t r;
    r.op = op;
    r.sc = sc;
    r.rv = rv;
    r.aim = aim;
    r.nudge = nudge;
    pending.insert(pending.size(), r);
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending.size() != 0 || item_valid || expected_picks.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_size(input logic [rws_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // acceptance, prediction and watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      if (cfg_we && !rst) wheel_size = cfg_wdata;
      item_taken <= item_valid && item_ready;
      if (item_valid && item_ready) apply_item(opcode, score, random_value);
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !item_taken) begin
      // hold until the transaction is accepted
    end else if (send_gap > 0) begin
      send_gap--;
      item_valid <= 1'b0;
    end else if (pending.size() > 0) begin
      nxt_req = pending.pop_front();
      if (nxt_req.aim >= 0)
        nxt_req.rv = wheel[WIDX_W'(nxt_req.aim % eff_size())] +
                     rws_pkg::RAND_W'(nxt_req.nudge);
      opcode <= nxt_req.op;
      score <= nxt_req.sc;
      random_value <= nxt_req.rv;
      item_valid <= 1'b1;
      send_gap = pace();
    end else begin
      item_valid <= 1'b0;
    end
  end

  // monitor
  always @(negedge clk) begin
    if (res_taken) take_wait = pace();
    if (take_wait > 0) begin
      take_wait--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_taken <= result_valid && result_ready;
    if (result_valid && result_ready) begin
      if (expected_picks.size() == 0) begin
        errors++;
        $display("%0t: selected_index expected none, actual %0d", $time, selected_index);
      end else if (expected_picks[0] !== selected_index) begin
        errors++;
        $display("%0t: selected_index expected %0d, actual %0d",
                 $time, expected_picks[0], selected_index);
        void'(expected_picks.pop_front());
      end else begin
        void'(expected_picks.pop_front());
      end
    end
  end

  initial begin
    int n_items;
    int sz;
    int eff;
    int tabs;
    int loads;
    int draws;
    logic [rws_pkg::SCORE_W-1:0] sc;
    bit first;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset size, saturating first entry: every draw hits entry 0
    queue_item(rws_pkg::OP_LOAD, 24'hFFFFFF, '0, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, rws_pkg::WHEEL_TOP, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, '0, -1, 0);
    settle();
    // size below 2 acts as 2; count already complete so the load restarts
    write_size(8'd0);
    queue_item(rws_pkg::OP_LOAD, '0, '0, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, '0, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, 31'd1, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, rws_pkg::WHEEL_TOP, -1, 0);
    settle();
    write_size(8'd1);
    queue_item(rws_pkg::OP_LOAD, 24'h010000, '0, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, 31'd1073741823, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, 31'd1073741824, -1, 0);
    settle();
    write_size(8'd3);
    queue_item(rws_pkg::OP_LOAD, 24'h010000, '0, -1, 0);
    queue_item(rws_pkg::OP_LOAD, 24'h010000, '0, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, 31'h2AAAAAAA, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, 31'h2AAAAAAB, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, 31'h55555555, -1, 0);
    // new table after a complete one, then a draw over the stale entry
    queue_item(rws_pkg::OP_LOAD, 24'h000001, '0, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, 31'd10922, -1, 0);
    queue_item(rws_pkg::OP_DRAW, '0, 31'd10923, -1, 0);
    settle();

    // first phase at the largest size fills every entry of the table
    n_items = 0;
    first = 1'b1;
    while (n_items < RANDOM_ITEMS) begin
      if (first) begin
        sz = 255;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            case ($urandom_range(0, 3))
              0: sz = 127;
              1: sz = 128;
              2: sz = 129;
              default: sz = 255;
            endcase
          end
          1: sz = $urandom_range(0, 1);
          default: sz = $urandom_range(2, 12);
        endcase
      end
      eff = (sz < 2) ? 2 : ((sz > WHEEL_MAX) ? WHEEL_MAX : sz);
      calm = ($urandom_range(0, 3) == 0);
      write_size(rws_pkg::CFG_W'(sz));
      tabs = (eff > 16) ? 1 : $urandom_range(2, 6);
      for (int t = 0; t < tabs; t++) begin
        loads = (first || eff > 16 || $urandom_range(0, 5) != 0) ? eff - 1
                                                                   : $urandom_range(1, eff + 1);
        for (int k = 0; k < loads; k++) begin
          case ($urandom_range(0, 9))
            0: sc = '0;
            1: sc = rws_pkg::SCORE_W'($urandom_range(0, 24'hFFFFFF));
            default: sc = rws_pkg::SCORE_W'($urandom_range(0, 24'h20000));
          endcase
          queue_item(rws_pkg::OP_LOAD, sc, '0, -1, 0);
        end
        draws = $urandom_range(1, 8);
        for (int k = 0; k < draws; k++) begin
          if ($urandom_range(0, 2) == 0)
            queue_item(rws_pkg::OP_DRAW, '0, '0, $urandom_range(0, WHEEL_MAX - 1),
                       $urandom_range(0, 2) - 1);
          else
            queue_item(rws_pkg::OP_DRAW, '0,
                       rws_pkg::RAND_W'($urandom_range(0, 32'h7FFFFFFF)), -1, 0);
        end
        n_items += loads + draws;
      end
      first = 1'b0;
      settle();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
